// ----- sv/brsr_pkg.sv -----
// Shared types, constants and helpers for the boot stage recovery record.
// No dependencies; imported by brsr_hash, boot_stage_recovery_record and brsr_checker.
package brsr_pkg;

  localparam int unsigned FIRST_CODE  = 1;
  localparam int unsigned STAGE_COUNT = 8;

  localparam logic [31:0] HASH_BASIS = 32'd2166136261;
  localparam logic [31:0] HASH_PRIME = 32'd16777619;

  localparam logic [7:0]  STAGE_LO   = 8'(FIRST_CODE);
  localparam logic [7:0]  STAGE_HI   = 8'(FIRST_CODE + STAGE_COUNT - 1);
  localparam logic [15:0] ALL_STAGES =
    (STAGE_COUNT >= 16) ? 16'hFFFF : 16'((32'd1 << STAGE_COUNT) - 32'd1);

  typedef enum logic [2:0] {
    CMD_LOAD  = 3'd0,
    CMD_BEGIN = 3'd1,
    CMD_ENTER = 3'd2,
    CMD_LEAVE = 3'd3,
    CMD_CLEAR = 3'd4,
    CMD_QUERY = 3'd5
  } cmd_e;

  localparam logic CFG_MAGIC   = 1'b0;
  localparam logic CFG_VERSION = 1'b1;

  // Words covered by the checksum
  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] version;
    logic [15:0] mask;
    logic [7:0]  stage;
  } hash_words_t;

  function automatic logic is_stage(input logic [7:0] code);
    is_stage = (code >= STAGE_LO) && (code <= STAGE_HI);
  endfunction

  function automatic logic [15:0] stage_bit(input logic [7:0] code);
    logic [7:0] diff;
    diff = code - STAGE_LO;
    stage_bit = is_stage(code) ? (16'd1 << diff[3:0]) : 16'd0;
  endfunction

endpackage

// ----- sv/brsr_hash.sv -----
// Iterative FNV-1a style checksum over four record words, one mix per cycle.
// Depends on brsr_pkg.
module brsr_hash import brsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  hash_words_t words_i,
  output logic        done_o,
  output logic [31:0] hash_o
);

  logic [31:0] acc_q, acc_d;
  logic [1:0]  idx_q, idx_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [31:0] word_sel, acc_sel, mixed;

  always_comb begin
    case (idx_q)
      2'd1:    word_sel = words_i.version;
      2'd2:    word_sel = 32'(words_i.mask);
      2'd3:    word_sel = 32'(words_i.stage);
      default: word_sel = words_i.magic;
    endcase
    if (start_i) begin
      word_sel = words_i.magic;
    end
    acc_sel = start_i ? HASH_BASIS : acc_q;
    mixed   = (acc_sel ^ word_sel) * HASH_PRIME;
  end

  always_comb begin
    acc_d  = acc_q;
    idx_d  = idx_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      acc_d = mixed;
      idx_d = 2'd1;
      run_d = 1'b1;
    end else if (run_q) begin
      acc_d = mixed;
      idx_d = idx_q + 2'd1;
      if (idx_q == 2'd3) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= 2'd0;
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      idx_q  <= idx_d;
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign hash_o = acc_q;

endmodule

// ----- sv/boot_stage_recovery_record.sv -----
// Boot stage recovery record: retained record with checksum, command sequencer.
// done_o strobes once the record has been checked, or once it has been resealed
// when the command reseals the record (begin, and enter or leave that take effect).
// Busy stays high until the strobe, and the next request can be taken in the
// strobe cycle; a new request is not accepted while one is in progress.
// Reset clears the record to zero, the expected magic to 0 and the expected version to 1.
module boot_stage_recovery_record import brsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic [2:0]  command_i,
  input  logic        crash_reset_i,
  input  logic        manual_safe_boot_i,
  input  logic [7:0]  stage_i,
  input  logic [31:0] load_magic_i,
  input  logic [31:0] load_version_i,
  input  logic [15:0] mask_in_i,
  input  logic [7:0]  load_stage_i,
  input  logic [31:0] load_check_i,
  output logic [15:0] decision_mask_o,
  output logic        recovery_active_o,
  output logic        manual_mode_o,
  output logic [7:0]  failed_stage_o,
  output logic        was_valid_o,
  output logic        skip_hit_o,
  output logic [31:0] rec_magic_o,
  output logic [31:0] rec_version_o,
  output logic [15:0] rec_mask_o,
  output logic [7:0]  rec_stage_o,
  output logic [31:0] rec_check_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SEAL
  } state_e;

  state_e      state_q;
  logic [31:0] exp_magic_q, exp_version_q;

  // Retained record
  logic [31:0] magic_q, version_q, check_q;
  logic [15:0] mask_q;
  logic [7:0]  stage_q;

  // Latched request
  logic [2:0]  cmd_q;
  logic        crash_q, manual_q;
  logic [7:0]  req_stage_q;
  logic [15:0] req_mask_q;
  logic [31:0] ld_magic_q, ld_version_q, ld_check_q;
  logic [7:0]  ld_stage_q;

  // Result
  logic        done_q, valid_q, active_q, manual_out_q, hit_q;
  logic [15:0] dmask_q;
  logic [7:0]  failed_q;

  logic        hash_done;
  hash_words_t hwords;
  logic [31:0] hash;
  logic        hstart_q;

  logic        valid_now;
  logic [15:0] crash_mask;

  assign hwords = '{magic: magic_q, version: version_q, mask: mask_q, stage: stage_q};

  brsr_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (hstart_q),
    .words_i (hwords),
    .done_o  (hash_done),
    .hash_o  (hash)
  );

  assign valid_now = (magic_q == exp_magic_q) && (version_q == exp_version_q) &&
                     ((stage_q == 8'd0) || is_stage(stage_q)) &&
                     ((mask_q & ~ALL_STAGES) == 16'd0) && (check_q == hash);
  assign crash_mask = mask_q | stage_bit(stage_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_magic_q   <= 32'd0;
      exp_version_q <= 32'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MAGIC:   exp_magic_q   <= cfg_data_i;
        CFG_VERSION: exp_version_q <= cfg_data_i;
        default:     exp_magic_q   <= exp_magic_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      hstart_q     <= 1'b0;
      done_q       <= 1'b0;
      magic_q      <= 32'd0;
      version_q    <= 32'd0;
      mask_q       <= 16'd0;
      stage_q      <= 8'd0;
      check_q      <= 32'd0;
      valid_q      <= 1'b0;
      active_q     <= 1'b0;
      manual_out_q <= 1'b0;
      hit_q        <= 1'b0;
      dmask_q      <= 16'd0;
      failed_q     <= 8'd0;
    end else begin
      hstart_q <= 1'b0;
      done_q   <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q  <= ST_CHECK;
            hstart_q <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (hash_done) begin
            valid_q      <= valid_now;
            dmask_q      <= 16'd0;
            active_q     <= 1'b0;
            manual_out_q <= 1'b0;
            failed_q     <= 8'd0;
            hit_q        <= 1'b0;
            state_q      <= ST_IDLE;
            done_q       <= 1'b1;
            case (cmd_q)
              CMD_LOAD: begin
                magic_q   <= ld_magic_q;
                version_q <= ld_version_q;
                mask_q    <= req_mask_q;
                stage_q   <= ld_stage_q;
                check_q   <= ld_check_q;
              end
              CMD_BEGIN: begin
                if (manual_q) begin
                  dmask_q      <= ALL_STAGES;
                  mask_q       <= ALL_STAGES;
                  active_q     <= 1'b1;
                  manual_out_q <= 1'b1;
                end else if (crash_q && valid_now) begin
                  dmask_q  <= crash_mask;
                  mask_q   <= crash_mask;
                  active_q <= (crash_mask != 16'd0);
                  failed_q <= is_stage(stage_q) ? stage_q : 8'd0;
                end else begin
                  mask_q <= 16'd0;
                end
                stage_q   <= 8'd0;
                magic_q   <= exp_magic_q;
                version_q <= exp_version_q;
                state_q   <= ST_SEAL;
                hstart_q  <= 1'b1;
                done_q    <= 1'b0;
              end
              CMD_ENTER: begin
                if (valid_now && (stage_bit(req_stage_q) != 16'd0)) begin
                  stage_q   <= req_stage_q;
                  magic_q   <= exp_magic_q;
                  version_q <= exp_version_q;
                  state_q   <= ST_SEAL;
                  hstart_q  <= 1'b1;
                  done_q    <= 1'b0;
                end
              end
              CMD_LEAVE: begin
                if (valid_now && (stage_q == req_stage_q)) begin
                  stage_q   <= 8'd0;
                  magic_q   <= exp_magic_q;
                  version_q <= exp_version_q;
                  state_q   <= ST_SEAL;
                  hstart_q  <= 1'b1;
                  done_q    <= 1'b0;
                end
              end
              CMD_CLEAR: begin
                magic_q   <= 32'd0;
                version_q <= 32'd0;
                mask_q    <= 16'd0;
                stage_q   <= 8'd0;
                check_q   <= 32'd0;
              end
              CMD_QUERY: begin
                hit_q <= ((req_mask_q & stage_bit(req_stage_q)) != 16'd0);
              end
              default: begin
                hit_q <= 1'b0;
              end
            endcase
          end
        end
        ST_SEAL: begin
          if (hash_done) begin
            check_q <= hash;
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Capture the request on acceptance
  always_ff @(posedge clk_i) begin
    if (start && (state_q == ST_IDLE)) begin
      cmd_q        <= command_i;
      crash_q      <= crash_reset_i;
      manual_q     <= manual_safe_boot_i;
      req_stage_q  <= stage_i;
      req_mask_q   <= mask_in_i;
      ld_magic_q   <= load_magic_i;
      ld_version_q <= load_version_i;
      ld_stage_q   <= load_stage_i;
      ld_check_q   <= load_check_i;
    end
  end

  assign busy              = (state_q != ST_IDLE);
  assign done_o            = done_q;
  assign decision_mask_o   = dmask_q;
  assign recovery_active_o = active_q;
  assign manual_mode_o     = manual_out_q;
  assign failed_stage_o    = failed_q;
  assign was_valid_o       = valid_q;
  assign skip_hit_o        = hit_q;
  assign rec_magic_o       = magic_q;
  assign rec_version_o     = version_q;
  assign rec_mask_o        = mask_q;
  assign rec_stage_o       = stage_q;
  assign rec_check_o       = check_q;

endmodule

// ----- sv/brsr_checker.sv -----
// Port-level checks for boot_stage_recovery_record, bound to the top level.
// Depends on brsr_pkg for the stage set.
module brsr_checker import brsr_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [15:0] decision_mask_o,
  input logic        recovery_active_o,
  input logic        manual_mode_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request accepted but busy not raised");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while still busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");

  a_mask_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (decision_mask_o != 16'd0)) |-> recovery_active_o)
    else $error("skip mask set without recovery");

  a_manual_all: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && manual_mode_o) |-> (recovery_active_o && (decision_mask_o == ALL_STAGES)))
    else $error("manual recovery without full skip mask");

endmodule

bind boot_stage_recovery_record brsr_checker u_brsr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start             (start),
  .busy              (busy),
  .done_o            (done_o),
  .decision_mask_o   (decision_mask_o),
  .recovery_active_o (recovery_active_o),
  .manual_mode_o     (manual_mode_o)
);
